// ----- rtl/assert_macros.svh -----
// assertion macros used by rpdc_datapath
// no dependencies; expects a clock named clk and a reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/rpdc_pkg.sv -----
// types and constants of the palette dedup cache
// no dependencies
`timescale 1ns / 1ps

package rpdc_pkg;

  localparam int HASH_W   = 64;
  localparam int ADDR_W   = 32;
  localparam int SIZE_W   = 23;
  localparam int LEN_W    = 9;
  localparam int REFS_W   = 16;
  localparam int WORD_W   = 32;
  localparam int LIVE_W   = 7;
  localparam int SHARED_W = 31;
  localparam int LEN_CMP_W = 12;

  localparam logic [REFS_W-1:0] REFS_MAX = 16'hFFFF;

  localparam logic [1:0] OP_ACQUIRE = 2'd0;
  localparam logic [1:0] OP_INSERT  = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_RESET   = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic [WORD_W-1:0] palette_word;
    logic              word_last;
    logic [HASH_W-1:0] palette_hash;
    logic [LEN_W-1:0]  palette_length;
    logic [ADDR_W-1:0] vram_address;
    logic [SIZE_W-1:0] vram_bytes;
  } request_t;

  typedef struct packed {
    logic                success;
    logic [ADDR_W-1:0]   found_address;
    logic [LIVE_W-1:0]   live_entries;
    logic [SHARED_W-1:0] shared_bytes;
  } result_t;

  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] size;
    logic [LEN_W-1:0]  length;
    logic [REFS_W-1:0] refs;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_CMP_RD, S_CMP_CHK, S_ACQ_WB,
    S_INS_RD, S_INS_WR, S_INS_META, S_REL_RD, S_REL_CHK, S_LAST_RD,
    S_LAST_WR, S_CP_RD, S_CP_WR, S_FIN
  } state_t;

  typedef struct packed {
    logic accept;
    logic clr_idx;
    logic inc_idx;
    logic clr_w;
    logic inc_w;
    logic meta_rd;
    logic rd_last;
    logic store_rd;
    logic buf_rd;
    logic acq_wb;
    logic rel_dec;
    logic meta_copy;
    logic ins_meta;
    logic ins_wr;
    logic cp_wr;
    logic live_dec;
    logic res_ok;
    logic res_hit;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       last;
    logic       req_ok;
    logic       len_fit;
    logic       room;
    logic       idx_end;
    logic       idx_is_last;
    logic       meta_hit;
    logic       addr_hit;
    logic       word_eq;
    logic       w_end;
    logic       cp_end;
    logic       refs_gt1;
  } stat_t;

endpackage

// ----- rtl/rpdc_datapath.sv -----
// datapath of the palette dedup cache: entry table, palette store, request buffer
// depends on rpdc_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rpdc_datapath #(
  parameter int MAX_ENTRIES = 64,
  parameter int MAX_PALETTE = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  rpdc_pkg::request_t request,
  input  rpdc_pkg::cmd_t     cmd,
  output rpdc_pkg::stat_t    stat,
  output logic               done,
  output rpdc_pkg::result_t  result
);

  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int WIDX_W = $clog2(MAX_PALETTE);
  localparam int WC_W   = $clog2(MAX_PALETTE + 2);
  localparam int ST_W   = $clog2(MAX_ENTRIES * MAX_PALETTE);
  localparam int SUM_W  = rpdc_pkg::REFS_W + rpdc_pkg::SIZE_W + IDX_W + 1;
  localparam int LCW    = rpdc_pkg::LEN_CMP_W;

  rpdc_pkg::entry_t meta_mem [MAX_ENTRIES];
  logic [rpdc_pkg::WORD_W-1:0] store_mem [MAX_ENTRIES * MAX_PALETTE];
  logic [rpdc_pkg::WORD_W-1:0] buf_mem [MAX_PALETTE];

  logic [CNT_W-1:0]  live;
  logic [SUM_W-1:0]  shared;
  logic [WC_W-1:0]   wc;
  logic [WC_W-1:0]   wc_inc;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  last_slot;
  logic [WIDX_W-1:0] w;
  logic              res_success;
  logic [rpdc_pkg::ADDR_W-1:0] res_found;

  logic [rpdc_pkg::HASH_W-1:0] rq_hash;
  logic [rpdc_pkg::LEN_W-1:0]  rq_len;
  logic [rpdc_pkg::ADDR_W-1:0] rq_addr;
  logic [rpdc_pkg::SIZE_W-1:0] rq_bytes;

  rpdc_pkg::entry_t            meta_q;
  logic [rpdc_pkg::WORD_W-1:0] store_q;
  logic [rpdc_pkg::WORD_W-1:0] buf_q;

  logic             word_op;
  logic [IDX_W-1:0] meta_raddr;
  logic [IDX_W-1:0] meta_waddr;
  logic             meta_we;
  rpdc_pkg::entry_t meta_wdata;
  logic [ST_W-1:0]  st_idx_addr;
  logic [ST_W-1:0]  st_live_addr;
  logic [ST_W-1:0]  st_last_addr;
  logic             refs_sat;

  assign word_op   = (request.op == rpdc_pkg::OP_ACQUIRE) || (request.op == rpdc_pkg::OP_INSERT);
  assign wc_inc    = (wc <= WC_W'(MAX_PALETTE)) ? wc + 1'b1 : wc;
  assign last_slot = live - 1'b1;
  assign refs_sat  = (meta_q.refs == rpdc_pkg::REFS_MAX);

  assign st_idx_addr  = ST_W'(idx[IDX_W-1:0]) * ST_W'(MAX_PALETTE) + ST_W'(w);
  assign st_live_addr = ST_W'(live[IDX_W-1:0]) * ST_W'(MAX_PALETTE) + ST_W'(w);
  assign st_last_addr = ST_W'(last_slot[IDX_W-1:0]) * ST_W'(MAX_PALETTE) + ST_W'(w);

  // status
  always_comb begin
    stat.op          = request.op;
    stat.last        = request.word_last;
    stat.req_ok      = (request.palette_length != '0) &&
                       (LCW'(request.palette_length) == LCW'(wc_inc));
    stat.len_fit     = LCW'(request.palette_length) <= LCW'(MAX_PALETTE);
    stat.room        = live < CNT_W'(MAX_ENTRIES);
    stat.idx_end     = (idx == live);
    stat.idx_is_last = (idx == last_slot);
    stat.meta_hit    = (meta_q.hash == rq_hash) && (meta_q.length == rq_len);
    stat.addr_hit    = (meta_q.address == rq_addr);
    stat.word_eq     = (store_q == buf_q);
    stat.w_end       = (LCW'(w) + 1'b1) == LCW'(rq_len);
    stat.cp_end      = (LCW'(w) + 1'b1) == LCW'(meta_q.length);
    stat.refs_gt1    = meta_q.refs > rpdc_pkg::REFS_W'(1);
  end

  // entry table write port and read address
  always_comb begin
    meta_we    = cmd.acq_wb || cmd.rel_dec || cmd.meta_copy || cmd.ins_meta;
    meta_waddr = idx[IDX_W-1:0];
    meta_wdata = meta_q;
    meta_raddr = cmd.rd_last ? last_slot[IDX_W-1:0] : idx[IDX_W-1:0];
    if (cmd.acq_wb) begin
      meta_wdata.refs = refs_sat ? meta_q.refs : meta_q.refs + 1'b1;
    end else if (cmd.rel_dec) begin
      meta_wdata.refs = meta_q.refs - 1'b1;
    end else if (cmd.ins_meta) begin
      meta_waddr         = live[IDX_W-1:0];
      meta_wdata.hash    = rq_hash;
      meta_wdata.address = rq_addr;
      meta_wdata.size    = rq_bytes;
      meta_wdata.length  = rq_len;
      meta_wdata.refs    = rpdc_pkg::REFS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (cmd.meta_rd) begin
      meta_q <= meta_mem[meta_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_wr) begin
      store_mem[st_live_addr] <= buf_q;
    end else if (cmd.cp_wr) begin
      store_mem[st_idx_addr] <= store_q;
    end
    if (cmd.store_rd) begin
      store_q <= store_mem[cmd.rd_last ? st_last_addr : st_idx_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && word_op && (wc < WC_W'(MAX_PALETTE))) begin
      buf_mem[wc[WIDX_W-1:0]] <= request.palette_word;
    end
    if (cmd.buf_rd) begin
      buf_q <= buf_mem[w];
    end
  end

  // request fields and result word
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rq_hash  <= request.palette_hash;
      rq_len   <= request.palette_length;
      rq_addr  <= request.vram_address;
      rq_bytes <= request.vram_bytes;
    end
    if (cmd.emit) begin
      result.success       <= res_success;
      result.found_address <= res_found;
      result.live_entries  <= rpdc_pkg::LIVE_W'(live);
      result.shared_bytes  <= (|shared[SUM_W-1:rpdc_pkg::SHARED_W]) ?
                              {rpdc_pkg::SHARED_W{1'b1}} : shared[rpdc_pkg::SHARED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live        <= '0;
      shared      <= '0;
      wc          <= '0;
      idx         <= '0;
      w           <= '0;
      res_success <= 1'b0;
      res_found   <= '0;
      done        <= 1'b0;
    end else begin
      done <= cmd.emit;
      if (cmd.accept) begin
        wc          <= (word_op && !request.word_last) ? wc_inc : '0;
        res_success <= (request.op == rpdc_pkg::OP_RESET);
        res_found   <= '0;
        if (request.op == rpdc_pkg::OP_RESET) begin
          live   <= '0;
          shared <= '0;
        end
      end
      if (cmd.clr_idx) begin
        idx <= '0;
      end else if (cmd.inc_idx) begin
        idx <= idx + 1'b1;
      end
      if (cmd.clr_w) begin
        w <= '0;
      end else if (cmd.inc_w) begin
        w <= w + 1'b1;
      end
      if (cmd.acq_wb && !refs_sat) begin
        shared <= shared + SUM_W'(meta_q.size);
      end else if (cmd.rel_dec) begin
        shared <= shared - SUM_W'(meta_q.size);
      end
      if (cmd.ins_meta) begin
        live <= live + 1'b1;
      end else if (cmd.live_dec) begin
        live <= live - 1'b1;
      end
      if (cmd.res_hit) begin
        res_success <= 1'b1;
        res_found   <= meta_q.address;
      end else if (cmd.res_ok) begin
        res_success <= 1'b1;
      end
    end
  end

  `ASSERT_IMPL(a_ins_room, cmd.ins_meta, live < CNT_W'(MAX_ENTRIES))
  `ASSERT_IMPL(a_dec_nonempty, cmd.live_dec, live != '0)
  `ASSERT_IMPL(a_rel_refs, cmd.rel_dec, meta_q.refs > rpdc_pkg::REFS_W'(1))

endmodule

// ----- rtl/rpdc_ctrl.sv -----
// controller of the palette dedup cache: sequences scans, compares and copies
// depends on rpdc_pkg
`timescale 1ns / 1ps

module rpdc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  rpdc_pkg::stat_t stat,
  output logic            busy,
  output rpdc_pkg::cmd_t  cmd
);

  rpdc_pkg::state_t state;
  rpdc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rpdc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rpdc_pkg::S_IDLE: begin
        if (start) begin
          case (stat.op)
            rpdc_pkg::OP_ACQUIRE: begin
              if (stat.last) begin
                state_next = (stat.req_ok && stat.len_fit) ? rpdc_pkg::S_SCAN_RD
                                                           : rpdc_pkg::S_FIN;
              end
            end
            rpdc_pkg::OP_INSERT: begin
              if (stat.last) begin
                state_next = (stat.req_ok && stat.len_fit && stat.room) ?
                             rpdc_pkg::S_INS_RD : rpdc_pkg::S_FIN;
              end
            end
            rpdc_pkg::OP_RELEASE: state_next = rpdc_pkg::S_REL_RD;
            default:              state_next = rpdc_pkg::S_FIN;
          endcase
        end
      end
      rpdc_pkg::S_SCAN_RD:  state_next = stat.idx_end ? rpdc_pkg::S_FIN : rpdc_pkg::S_SCAN_CHK;
      rpdc_pkg::S_SCAN_CHK: state_next = stat.meta_hit ? rpdc_pkg::S_CMP_RD : rpdc_pkg::S_SCAN_RD;
      rpdc_pkg::S_CMP_RD:   state_next = rpdc_pkg::S_CMP_CHK;
      rpdc_pkg::S_CMP_CHK: begin
        if (!stat.word_eq) begin
          state_next = rpdc_pkg::S_SCAN_RD;
        end else begin
          state_next = stat.w_end ? rpdc_pkg::S_ACQ_WB : rpdc_pkg::S_CMP_RD;
        end
      end
      rpdc_pkg::S_ACQ_WB:   state_next = rpdc_pkg::S_FIN;
      rpdc_pkg::S_INS_RD:   state_next = rpdc_pkg::S_INS_WR;
      rpdc_pkg::S_INS_WR:   state_next = stat.w_end ? rpdc_pkg::S_INS_META : rpdc_pkg::S_INS_RD;
      rpdc_pkg::S_INS_META: state_next = rpdc_pkg::S_FIN;
      rpdc_pkg::S_REL_RD:   state_next = stat.idx_end ? rpdc_pkg::S_FIN : rpdc_pkg::S_REL_CHK;
      rpdc_pkg::S_REL_CHK: begin
        if (!stat.addr_hit) begin
          state_next = rpdc_pkg::S_REL_RD;
        end else if (stat.refs_gt1 || stat.idx_is_last) begin
          state_next = rpdc_pkg::S_FIN;
        end else begin
          state_next = rpdc_pkg::S_LAST_RD;
        end
      end
      rpdc_pkg::S_LAST_RD:  state_next = rpdc_pkg::S_LAST_WR;
      rpdc_pkg::S_LAST_WR:  state_next = rpdc_pkg::S_CP_RD;
      rpdc_pkg::S_CP_RD:    state_next = rpdc_pkg::S_CP_WR;
      rpdc_pkg::S_CP_WR:    state_next = stat.cp_end ? rpdc_pkg::S_FIN : rpdc_pkg::S_CP_RD;
      rpdc_pkg::S_FIN:      state_next = rpdc_pkg::S_IDLE;
      default:              state_next = rpdc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != rpdc_pkg::S_IDLE);
    case (state)
      rpdc_pkg::S_IDLE: begin
        cmd.accept  = start;
        cmd.clr_idx = start;
        cmd.clr_w   = start;
      end
      rpdc_pkg::S_SCAN_RD: begin
        cmd.meta_rd = !stat.idx_end;
      end
      rpdc_pkg::S_SCAN_CHK: begin
        cmd.clr_w   = stat.meta_hit;
        cmd.inc_idx = !stat.meta_hit;
      end
      rpdc_pkg::S_CMP_RD: begin
        cmd.store_rd = 1'b1;
        cmd.buf_rd   = 1'b1;
      end
      rpdc_pkg::S_CMP_CHK: begin
        cmd.inc_idx = !stat.word_eq;
        cmd.clr_w   = !stat.word_eq;
        cmd.inc_w   = stat.word_eq && !stat.w_end;
      end
      rpdc_pkg::S_ACQ_WB: begin
        cmd.acq_wb  = 1'b1;
        cmd.res_hit = 1'b1;
      end
      rpdc_pkg::S_INS_RD: begin
        cmd.buf_rd = 1'b1;
      end
      rpdc_pkg::S_INS_WR: begin
        cmd.ins_wr = 1'b1;
        cmd.inc_w  = !stat.w_end;
      end
      rpdc_pkg::S_INS_META: begin
        cmd.ins_meta = 1'b1;
        cmd.res_ok   = 1'b1;
      end
      rpdc_pkg::S_REL_RD: begin
        cmd.meta_rd = !stat.idx_end;
        cmd.res_ok  = stat.idx_end;
      end
      rpdc_pkg::S_REL_CHK: begin
        cmd.inc_idx = !stat.addr_hit;
        if (stat.addr_hit) begin
          cmd.rel_dec  = stat.refs_gt1;
          cmd.res_ok   = !stat.refs_gt1;
          cmd.live_dec = !stat.refs_gt1 && stat.idx_is_last;
        end
      end
      rpdc_pkg::S_LAST_RD: begin
        cmd.meta_rd = 1'b1;
        cmd.rd_last = 1'b1;
      end
      rpdc_pkg::S_LAST_WR: begin
        cmd.meta_copy = 1'b1;
        cmd.clr_w     = 1'b1;
      end
      rpdc_pkg::S_CP_RD: begin
        cmd.store_rd = 1'b1;
        cmd.rd_last  = 1'b1;
      end
      rpdc_pkg::S_CP_WR: begin
        cmd.cp_wr    = 1'b1;
        cmd.inc_w    = !stat.cp_end;
        cmd.live_dec = stat.cp_end;
      end
      rpdc_pkg::S_FIN: begin
        cmd.emit = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- rtl/refcounted_palette_dedup_cache.sv -----
// one word accepted at a time while busy is low; an acquire or insert word that does not end
// its request does not raise busy; other words hold busy through any table scan, the palette
// words compared or copied through the single-port palette store, and a final result state
// done marks the result in the same cycle busy falls; results cannot be stalled
// synchronous reset empties the table and clears the word count, no clearing pass
`timescale 1ns / 1ps

module refcounted_palette_dedup_cache #(
  parameter int MAX_ENTRIES = 64,
  parameter int MAX_PALETTE = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  rpdc_pkg::request_t request,
  output logic               done,
  output rpdc_pkg::result_t  result
);

  rpdc_pkg::cmd_t  cmd;
  rpdc_pkg::stat_t stat;

  rpdc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  rpdc_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_PALETTE (MAX_PALETTE)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .stat    (stat),
    .done    (done),
    .result  (result)
  );

endmodule

// ----- sim/refcounted_palette_dedup_cache_chk.sv -----
// checker for the palette dedup cache: predicts each result from the accepted words
// and compares it with the result strobe; depends on rpdc_pkg
`timescale 1ns / 1ps

module refcounted_palette_dedup_cache_chk (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  rpdc_pkg::request_t request,
  input  logic               done,
  input  rpdc_pkg::result_t  result,
  output int                 errors,
  output int                 pending
);

  localparam int ENTRIES = 64;
  localparam int PAL_MAX = 256;

  logic [rpdc_pkg::HASH_W-1:0] tab_hash [ENTRIES];
  logic [rpdc_pkg::ADDR_W-1:0] tab_addr [ENTRIES];
  logic [rpdc_pkg::SIZE_W-1:0] tab_size [ENTRIES];
  logic [rpdc_pkg::LEN_W-1:0]  tab_len  [ENTRIES];
  logic [rpdc_pkg::REFS_W-1:0] tab_refs [ENTRIES];
  logic [rpdc_pkg::WORD_W-1:0] tab_words [ENTRIES*PAL_MAX];
  logic [rpdc_pkg::WORD_W-1:0] req_words [PAL_MAX];
  int                          live;
  int                          word_cnt;
  rpdc_pkg::result_t           expected_q[$];

  function automatic bit bool_words_match(int slot, int n);
    for (int w = 0; w < n; w++)
      if (tab_words[slot*PAL_MAX+w] != req_words[w]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void drop_entry(int idx);
    int last;
    last = live - 1;
    if (idx != last) begin
      tab_hash[idx] = tab_hash[last];
      tab_addr[idx] = tab_addr[last];
      tab_size[idx] = tab_size[last];
      tab_len[idx]  = tab_len[last];
      tab_refs[idx] = tab_refs[last];
      for (int w = 0; w < PAL_MAX; w++) tab_words[idx*PAL_MAX+w] = tab_words[last*PAL_MAX+w];
    end
    live = last;
  endfunction

  // returns 1 when the word produces a result
  function automatic bit cache_step(rpdc_pkg::request_t r, output rpdc_pkg::result_t res);
    longint unsigned sum;
    int n;
    res = '0;
    n = int'(r.palette_length);
    if (r.op == rpdc_pkg::OP_ACQUIRE || r.op == rpdc_pkg::OP_INSERT) begin
      if (word_cnt < PAL_MAX) req_words[word_cnt] = r.palette_word;
      if (word_cnt <= PAL_MAX) word_cnt++;
      if (!r.word_last) return 1'b0;
      if (n != 0 && n == word_cnt) begin
        if (r.op == rpdc_pkg::OP_ACQUIRE) begin
          for (int i = 0; i < live; i++) begin
            if (tab_hash[i] == r.palette_hash && tab_len[i] == r.palette_length &&
                n <= PAL_MAX && bool_words_match(i, n)) begin
              if (tab_refs[i] != rpdc_pkg::REFS_MAX) tab_refs[i]++;
              res.found_address = tab_addr[i];
              res.success = 1'b1;
              break;
            end
          end
        end else if (n <= PAL_MAX && live < ENTRIES) begin
          for (int w = 0; w < n; w++) tab_words[live*PAL_MAX+w] = req_words[w];
          tab_hash[live] = r.palette_hash;
          tab_addr[live] = r.vram_address;
          tab_size[live] = r.vram_bytes;
          tab_len[live]  = r.palette_length;
          tab_refs[live] = rpdc_pkg::REFS_W'(1);
          live++;
          res.success = 1'b1;
        end
      end
      word_cnt = 0;
    end else if (r.op == rpdc_pkg::OP_RELEASE) begin
      word_cnt = 0;
      res.success = 1'b1;
      for (int i = 0; i < live; i++) begin
        if (tab_addr[i] == r.vram_address) begin
          if (tab_refs[i] != 0) tab_refs[i]--;
          if (tab_refs[i] != 0) res.success = 1'b0;
          else drop_entry(i);
          break;
        end
      end
    end else begin
      word_cnt = 0;
      live = 0;
      res.success = 1'b1;
    end
    sum = 0;
    for (int i = 0; i < live; i++)
      if (tab_refs[i] != 0) sum += longint'(tab_refs[i] - 1) * longint'(tab_size[i]);
    res.live_entries = rpdc_pkg::LIVE_W'(live);
    res.shared_bytes = (sum > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : rpdc_pkg::SHARED_W'(sum);
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    rpdc_pkg::result_t exp_res;
    rpdc_pkg::result_t got;
    if (rst) begin
      live = 0;
      word_cnt = 0;
      errors = 0;
      expected_q.delete();
    end else begin
      if (done) begin
        got = result;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t unexpected result %h", $time, got);
        end else begin
          exp_res = expected_q.pop_front();
          if (got.success !== exp_res.success) begin
            errors++;
            $display("%0t success exp %h got %h", $time, exp_res.success, got.success);
          end
          if (got.found_address !== exp_res.found_address) begin
            errors++;
            $display("%0t found_address exp %h got %h", $time, exp_res.found_address,
                     got.found_address);
          end
          if (got.live_entries !== exp_res.live_entries) begin
            errors++;
            $display("%0t live_entries exp %0d got %0d", $time, exp_res.live_entries,
                     got.live_entries);
          end
          if (got.shared_bytes !== exp_res.shared_bytes) begin
            errors++;
            $display("%0t shared_bytes exp %h got %h", $time, exp_res.shared_bytes,
                     got.shared_bytes);
          end
        end
      end
      if (start && !busy && cache_step(request, exp_res)) expected_q.push_back(exp_res);
    end
    pending = expected_q.size();
  end

endmodule

// ----- sim/refcounted_palette_dedup_cache_tb.sv -----
// testbench top for the palette dedup cache: drives directed and random words,
// depends on rpdc_pkg, the cache and refcounted_palette_dedup_cache_chk
`timescale 1ns / 1ps

module refcounted_palette_dedup_cache_tb;

  localparam int IDLE_LIMIT = 200000;
  localparam int NPAL = 8;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               done;
  rpdc_pkg::request_t request = '0;
  rpdc_pkg::result_t  result;
  int                 errors;
  int                 pending;
  int                 idle_cycles = 0;
  int                 sent = 0;
  bit                 bursty = 0;

  logic [rpdc_pkg::WORD_W-1:0] pal_w [NPAL][256];
  logic [rpdc_pkg::HASH_W-1:0] pal_h [NPAL];
  int                          pal_n [NPAL] = '{1, 2, 3, 4, 6, 8, 16, 256};
  logic [rpdc_pkg::ADDR_W-1:0] addr_pool [12];
  logic [rpdc_pkg::WORD_W-1:0] run_w [300];

  refcounted_palette_dedup_cache uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .request(request), .done(done), .result(result)
  );

  refcounted_palette_dedup_cache_chk chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .result(result), .errors(errors), .pending(pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic put_word(rpdc_pkg::request_t r);
    int gap;
    gap = bursty ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  function automatic rpdc_pkg::request_t rand_req(logic [1:0] op);
    rpdc_pkg::request_t r;
    r.op = op;
    r.palette_word = $urandom;
    r.word_last = 1'($urandom_range(0, 1));
    r.palette_hash = {$urandom, $urandom};
    r.palette_length = rpdc_pkg::LEN_W'($urandom_range(0, 511));
    r.vram_address = $urandom;
    r.vram_bytes = rpdc_pkg::SIZE_W'($urandom_range(0, 4194304));
    return r;
  endfunction

  // a random word that does not end its request
  function automatic rpdc_pkg::request_t rand_mid(logic [1:0] op);
    rpdc_pkg::request_t r;
    r = rand_req(op);
    r.word_last = 1'b0;
    return r;
  endfunction

  // n words from run_w, final one carrying the request fields
  task automatic send_run(logic [1:0] op, int n, logic [rpdc_pkg::HASH_W-1:0] h, int len,
                          logic [rpdc_pkg::ADDR_W-1:0] a, logic [rpdc_pkg::SIZE_W-1:0] b);
    rpdc_pkg::request_t r;
    for (int i = 0; i < n; i++) begin
      r = rand_req(op);
      r.palette_word = run_w[i];
      r.word_last = (i == n - 1);
      if (i == n - 1) begin
        r.palette_hash = h;
        r.palette_length = rpdc_pkg::LEN_W'(len);
        r.vram_address = a;
        r.vram_bytes = b;
      end
      put_word(r);
    end
  endtask

  task automatic send_pal(logic [1:0] op, int p, logic [rpdc_pkg::ADDR_W-1:0] a,
                          logic [rpdc_pkg::SIZE_W-1:0] b);
    for (int i = 0; i < pal_n[p]; i++) run_w[i] = pal_w[p][i];
    send_run(op, pal_n[p], pal_h[p], pal_n[p], a, b);
  endtask

  task automatic send_ctl(logic [1:0] op, logic [rpdc_pkg::ADDR_W-1:0] a);
    rpdc_pkg::request_t r;
    r = rand_req(op);
    r.vram_address = a;
    put_word(r);
  endtask

  task automatic single(logic [1:0] op, logic [rpdc_pkg::WORD_W-1:0] w,
                        logic [rpdc_pkg::HASH_W-1:0] h, logic [rpdc_pkg::ADDR_W-1:0] a,
                        logic [rpdc_pkg::SIZE_W-1:0] b);
    run_w[0] = w;
    send_run(op, 1, h, 1, a, b);
  endtask

  initial begin
    int k;
    int p;
    int n;
    for (int i = 0; i < NPAL; i++) begin
      pal_h[i] = {$urandom, $urandom};
      for (int j = 0; j < 256; j++) pal_w[i][j] = $urandom;
    end
    for (int i = 0; i < 12; i++) addr_pool[i] = $urandom;
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed
    send_ctl(rpdc_pkg::OP_RESET, '0);
    run_w[0] = 32'h1234;
    send_run(rpdc_pkg::OP_INSERT, 1, '0, 0, 32'h10, 23'd5);
    single(rpdc_pkg::OP_INSERT, '0, '0, '0, '0);
    single(rpdc_pkg::OP_INSERT, '1, '1, '1, 23'd4194304);
    single(rpdc_pkg::OP_INSERT, '1, '1, 32'h20, 23'd7);
    single(rpdc_pkg::OP_ACQUIRE, '1, '1, '0, '0);
    single(rpdc_pkg::OP_ACQUIRE, '0, '0, '0, '0);
    single(rpdc_pkg::OP_ACQUIRE, 32'h5, '1, '0, '0);
    send_ctl(rpdc_pkg::OP_RELEASE, '1);
    send_ctl(rpdc_pkg::OP_RELEASE, '1);
    send_ctl(rpdc_pkg::OP_RELEASE, 32'hDEAD_BEEF);
    run_w[0] = 32'h1;
    run_w[1] = 32'h2;
    send_run(rpdc_pkg::OP_INSERT, 2, '0, 3, 32'h30, 23'd1);
    put_word(rand_mid(rpdc_pkg::OP_ACQUIRE));
    send_ctl(rpdc_pkg::OP_RELEASE, 32'h20);
    put_word(rand_mid(rpdc_pkg::OP_INSERT));
    send_ctl(rpdc_pkg::OP_RESET, '0);
    for (int i = 0; i < 257; i++) run_w[i] = $urandom;
    send_run(rpdc_pkg::OP_INSERT, 257, '1, 257, 32'h40, 23'd2);
    send_pal(rpdc_pkg::OP_INSERT, 6, 32'h50, 23'd100);
    send_pal(rpdc_pkg::OP_ACQUIRE, 6, '0, '0);

    // repeated hits on one entry, back to back
    bursty = 1;
    send_ctl(rpdc_pkg::OP_RESET, '0);
    single(rpdc_pkg::OP_INSERT, 32'hCAFE, 64'h77, 32'h60, 23'd4194304);
    repeat (16) single(rpdc_pkg::OP_ACQUIRE, 32'hCAFE, 64'h77, '0, '0);
    send_ctl(rpdc_pkg::OP_RELEASE, 32'h60);
    send_ctl(rpdc_pkg::OP_RESET, '0);
    bursty = 0;

    // full table
    for (int i = 0; i < 66; i++)
      single(rpdc_pkg::OP_INSERT, $urandom_range(0, 3), 64'h9,
             addr_pool[$urandom_range(0, 11)], rpdc_pkg::SIZE_W'($urandom_range(0, 4194304)));
    for (int i = 0; i < 10; i++)
      single(rpdc_pkg::OP_ACQUIRE, $urandom_range(0, 3), 64'h9, '0, '0);
    for (int i = 0; i < 20; i++)
      send_ctl(rpdc_pkg::OP_RELEASE, addr_pool[$urandom_range(0, 11)]);

    // random
    k = sent;
    while (sent - k < 100) begin
      if ($urandom_range(0, 15) == 0) bursty = !bursty;
      if (sent - k > 40 && sent - k < 60) begin
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      p = $urandom_range(0, NPAL - 2);
      if ($urandom_range(0, 40) == 0) p = NPAL - 1;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: send_pal(rpdc_pkg::OP_ACQUIRE, p, '0, '0);
        6, 7, 8, 9: send_pal(rpdc_pkg::OP_INSERT, p, addr_pool[$urandom_range(0, 11)],
                             rpdc_pkg::SIZE_W'($urandom_range(0, 4194304)));
        10, 11, 12: send_ctl(rpdc_pkg::OP_RELEASE, addr_pool[$urandom_range(0, 11)]);
        13: send_ctl(rpdc_pkg::OP_RELEASE, $urandom);
        14: send_ctl(rpdc_pkg::OP_RESET, '0);
        15: begin
          for (int i = 0; i < pal_n[p]; i++) run_w[i] = pal_w[p][i];
          run_w[$urandom_range(0, pal_n[p] - 1)] ^= 32'h1 << $urandom_range(0, 31);
          send_run(rpdc_pkg::OP_ACQUIRE, pal_n[p], pal_h[p], pal_n[p], '0, '0);
        end
        16: begin
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++) run_w[i] = $urandom;
          send_run(2'($urandom_range(0, 1)), n, {$urandom, $urandom}, $urandom_range(0, 8),
                   $urandom, rpdc_pkg::SIZE_W'($urandom_range(0, 4194304)));
        end
        17: begin
          n = $urandom_range(1, 4);
          for (int i = 0; i < n; i++) put_word(rand_mid(2'($urandom_range(0, 1))));
          send_ctl(2'($urandom_range(2, 3)), addr_pool[$urandom_range(0, 11)]);
        end
        default: put_word(rand_req(2'($urandom_range(0, 3))));
      endcase
    end
    start <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
